// ----- rtl/core/scs_pkg.sv -----
// package for the sparse coordinate store
// shared constants, function codes, payload types and widths; no dependencies
package scs_pkg;
    localparam int ENTRIES_DEF    = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int VALUE_BITS     = 32;
    localparam int PCT_BITS       = 7;
    localparam int COUNT_BITS     = 7;
    localparam int FUNC_BITS      = 2;

    localparam logic [FUNC_BITS-1:0] FUNC_SET    = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_GET    = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 2'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_NOP    = 2'd3;

    typedef struct packed {
        logic [FUNC_BITS-1:0]         func;
        logic [COORD_BITS_DEF-1:0]    row;
        logic [COORD_BITS_DEF-1:0]    col;
        logic signed [VALUE_BITS-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] read_value;
        logic                         hit;
        logic [COUNT_BITS-1:0]        entry_count;
        logic [PCT_BITS-1:0]          density_pct;
        logic                         full_error;
    } rsp_t;
endpackage

// ----- rtl/core/scs_if.sv -----
// valid/ready stream interface with generic payload
// depends on nothing; payload type is given by the instantiating scope
interface scs_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/sparse_coordinate_store.sv -----
// top level of the sparse coordinate store: cell row, control and density divider
// depends on scs_pkg, scs_if, scs_cell, scs_div
//
//  channel   dir  payload
//  req_in    in   func, row, col, value
//  rsp_out   out  read_value, hit, entry_count, density_pct, full_error
//
// in the compare state every cell checks the key, then on a set of a new
// key a free-slot scan of one slot a cycle, then the divider; the result is
// valid in S_OUT after S_DIV and S_WAIT, and after the result transfer the
// block returns to S_IDLE, where the next input is taken
// reset clears valid bits, count and maxima at once; no clearing pass
// input is ready only when idle, so a result waiting on rsp_out stalls the input
module sparse_coordinate_store
    import scs_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    scs_if.sink   req_in,
    scs_if.source rsp_out
);
    localparam int IDX_BITS = $clog2(ENTRIES);
    localparam int CNT_BITS = $clog2(ENTRIES + 1);
    localparam int NUM_BITS = CNT_BITS + 7;
    localparam int DEN_BITS = 2 * COORD_BITS + 2;

    typedef enum logic [2:0] {S_IDLE, S_LOOK, S_SCAN, S_DIV, S_WAIT, S_OUT} state_t;

    state_t                       state_reg;
    logic [FUNC_BITS-1:0]         func_reg;
    logic [COORD_BITS-1:0]        row_reg, col_reg, maxr_reg, maxc_reg;
    logic signed [VALUE_BITS-1:0] val_reg, rd_reg;
    logic                         hit_reg, ferr_reg;
    logic [CNT_BITS-1:0]          count_reg;
    logic [IDX_BITS-1:0]          ptr_reg;
    logic                         div_start;
    logic                         div_done;
    logic [PCT_BITS-1:0]          pct;

    logic [ENTRIES-1:0]           valid_v, match_v, wr_v, clr_v;
    logic signed [VALUE_BITS-1:0] value_a [ENTRIES];
    logic                         any_hit;
    logic [IDX_BITS-1:0]          hit_idx;
    logic                         is_del, is_set;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            scs_cell #(.COORD_BITS(COORD_BITS)) u_cell (
                .clk(clk), .rst_n(rst_n),
                .load(!valid_v[g]),
                .key_row(row_reg), .key_col(col_reg),
                .wr_en(wr_v[g]), .clr_en(clr_v[g]), .wr_value(val_reg),
                .valid(valid_v[g]), .match(match_v[g]), .value(value_a[g])
            );
        end
    endgenerate

    always_comb
    begin
        any_hit = |match_v;
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_v[i])
            begin
                hit_idx = IDX_BITS'(i);
            end
        end
    end

    assign is_del = (func_reg == FUNC_REMOVE) || (func_reg == FUNC_SET && val_reg == 0);
    assign is_set = (func_reg == FUNC_SET) && (val_reg != 0);

    always_comb
    begin
        wr_v  = '0;
        clr_v = '0;
        if (state_reg == S_LOOK && any_hit && is_set)
        begin
            wr_v[hit_idx] = 1'b1;
        end
        if (state_reg == S_LOOK && any_hit && is_del)
        begin
            clr_v[hit_idx] = 1'b1;
        end
        if (state_reg == S_SCAN && !valid_v[ptr_reg])
        begin
            wr_v[ptr_reg] = 1'b1;
        end
    end

    assign div_start = (state_reg == S_DIV);

    scs_div #(.NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(NUM_BITS'(count_reg) * NUM_BITS'(100)),
        .den((DEN_BITS'(maxr_reg) + 1'b1) * (DEN_BITS'(maxc_reg) + 1'b1)),
        .done(div_done), .pct(pct)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            maxr_reg  <= '0;
            maxc_reg  <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req_in.valid)
                    begin
                        func_reg  <= req_in.data.func;
                        row_reg   <= req_in.data.row[COORD_BITS-1:0];
                        col_reg   <= req_in.data.col[COORD_BITS-1:0];
                        val_reg   <= req_in.data.value;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    hit_reg  <= any_hit && (func_reg != FUNC_NOP);
                    ferr_reg <= 1'b0;
                    rd_reg   <= (func_reg == FUNC_GET && any_hit) ? value_a[hit_idx] : '0;
                    ptr_reg  <= '0;
                    if (any_hit && is_del)
                    begin
                        count_reg <= count_reg - 1'b1;
                    end
                    state_reg <= (is_set && !any_hit) ? S_SCAN : S_DIV;
                end
                S_SCAN:
                begin
                    if (!valid_v[ptr_reg])
                    begin
                        count_reg <= count_reg + 1'b1;
                        if (row_reg > maxr_reg) maxr_reg <= row_reg;
                        if (col_reg > maxc_reg) maxc_reg <= col_reg;
                        state_reg <= S_DIV;
                    end
                    else if (ptr_reg == IDX_BITS'(ENTRIES - 1))
                    begin
                        ferr_reg  <= 1'b1;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                S_DIV:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (rsp_out.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_in.ready              = (state_reg == S_IDLE);
    assign rsp_out.valid             = (state_reg == S_OUT);
    assign rsp_out.data.read_value   = rd_reg;
    assign rsp_out.data.hit          = hit_reg;
    assign rsp_out.data.entry_count  = COUNT_BITS'(count_reg);
    assign rsp_out.data.density_pct  = pct;
    assign rsp_out.data.full_error   = ferr_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(ENTRIES)) else $error("count overflow");
    a_count_bits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> $countones(valid_v) == count_reg)
        else $error("count mismatch");
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_v)) else $error("duplicate key");
    a_ferr_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && ferr_reg |-> count_reg == CNT_BITS'(ENTRIES))
        else $error("false full flag");
endmodule

// ----- rtl/core/scs_cell.sv -----
// one storage slot of the cell row, compares the broadcast key against its entry
// depends on scs_pkg
module scs_cell
    import scs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [COORD_BITS-1:0]        key_row,
    input  logic [COORD_BITS-1:0]        key_col,
    input  logic                         wr_en,
    input  logic                         clr_en,
    input  logic signed [VALUE_BITS-1:0] wr_value,
    output logic                         valid,
    output logic                         match,
    output logic signed [VALUE_BITS-1:0] value
);
    logic                         valid_reg;
    logic [COORD_BITS-1:0]        row_reg;
    logic [COORD_BITS-1:0]        col_reg;
    logic signed [VALUE_BITS-1:0] value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clr_en)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_en && load)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && load)
        begin
            row_reg <= key_row;
            col_reg <= key_col;
        end
        if (wr_en)
        begin
            value_reg <= wr_value;
        end
    end

    assign valid = valid_reg;
    assign match = valid_reg && (row_reg == key_row) && (col_reg == key_col);
    assign value = value_reg;
endmodule

// ----- rtl/core/scs_div.sv -----
// restoring divider for the density percentage, one quotient bit a cycle
// depends on scs_pkg
module scs_div
    import scs_pkg::*;
#(
    parameter int NUM_BITS = 20,
    parameter int DEN_BITS = 34
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                done,
    output logic [PCT_BITS-1:0] pct
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);
    localparam int REM_BITS = DEN_BITS + 1;

    logic [NUM_BITS-1:0] quo_reg;
    logic [REM_BITS-1:0] rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [REM_BITS-1:0] trial;

    assign trial = {rem_reg[REM_BITS-2:0], quo_reg[NUM_BITS-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= trial - {1'b0, den_reg};
                quo_reg <= {quo_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[NUM_BITS-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign pct = (quo_reg > NUM_BITS'(100)) ? PCT_BITS'(100) : quo_reg[PCT_BITS-1:0];
endmodule
